### hw/rtl/sha256_sha224_hasher_defines.svh
// Assertion macros for the SHA-256/SHA-224 hasher.
// Included by RTL files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef SHA256_SHA224_HASHER_DEFINES_SVH
`define SHA256_SHA224_HASHER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SHA2H_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SHA2H_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/sha2h_pkg.sv
// Shared types, codes and SHA-2 round functions for the SHA-256/SHA-224 hasher.
// No dependencies; used by sha256_sha224_hasher.
`default_nettype none

package sha2h_pkg;

    typedef logic [31:0] word_t;
    typedef word_t       chain_t [0:7];

    localparam int BLOCK_BYTES = 64;

    // Request kinds.
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    // Register index decoded from the word address.
    localparam logic REG_MODE = 1'b0;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam chain_t IV_256 = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam chain_t IV_224 = '{
        32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
        32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
    };

    localparam word_t ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    function automatic word_t choose(input word_t e, input word_t f, input word_t g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic word_t majority(input word_t a, input word_t b, input word_t c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/sha2h_msg_if.sv
// Request channel carrying message bytes and finish markers into the hasher.
// Standalone; valid/ready handshake.
`default_nettype none

interface sha2h_msg_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, kind, data_byte, input ready);
    modport sink (input valid, kind, data_byte, output ready);
endinterface

`default_nettype wire

### hw/rtl/sha2h_digest_if.sv
// Result channel carrying digest words out of the hasher.
// Standalone; valid/ready handshake.
`default_nettype none

interface sha2h_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

### hw/rtl/sha256_sha224_hasher.sv
// SHA-256 / SHA-224 hasher. Takes one message byte per request and a finish request, then
// returns eight digest words, most significant first (the eighth is zero in SHA-224 mode).
// Every 64th byte starts a compression (64 rounds through the single shared round unit plus
// one chaining add), during which no request is taken. A finish with f bytes pending pads
// the block with the marker, zeros and, when f is under 56, the bit count, then compresses it;
// when f is 56 or more, another padding block and compression follow, and then the eight result words. The byte
// window doubles as the message schedule, so no block buffer memory is needed. The mode
// register (address 0, bit 0, reset 1 = SHA-256) is sampled on the first request of a message.
// Depends on sha2h_pkg, sha2h_msg_if, sha2h_digest_if and the assertion macro header.
`default_nettype none

`include "sha256_sha224_hasher_defines.svh"

module sha256_sha224_hasher (
    input  wire logic         clk,
    input  wire logic         rst_n,
    sha2h_msg_if.sink         msg,
    sha2h_digest_if.source    dig,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready
);
    import sha2h_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_PAD      = 3'd1;
    localparam logic [2:0] ST_COMPRESS = 3'd2;
    localparam logic [2:0] ST_ADD      = 3'd3;
    localparam logic [2:0] ST_OUTPUT   = 3'd4;

    localparam logic [5:0] LAST_POS   = 6'(BLOCK_BYTES - 1);
    localparam logic [5:0] LENGTH_POS = 6'(BLOCK_BYTES - 8);

    logic [2:0]  state_reg, state_next;
    logic        mode_reg;
    logic        latched_reg, latched_next;
    logic        in_msg_reg, in_msg_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  idx_reg, idx_next;
    logic        pad_reg, pad_next;
    logic        final_reg, final_next;
    logic        first_reg, first_next;
    chain_t      chain_reg, chain_next;
    chain_t      v_reg, v_next;
    word_t       sched_reg [0:15];
    word_t       sched_next [0:15];

    logic        shift_byte;
    logic [7:0]  shift_val;
    logic [5:0]  fill_eff;
    logic [63:0] bits_eff;
    word_t       t1, t2, new_w;
    logic        cfg_write;

    // Configuration port: single mode bit at word address 0.
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_MODE) ? {31'b0, mode_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b1;
        end
        else if (cfg_write && (paddr[2] == REG_MODE))
        begin
            mode_reg <= pwdata[0];
        end
    end

    // Shared round unit and schedule expansion.
    assign fill_eff = in_msg_reg ? fill_reg : 6'd0;
    assign bits_eff = in_msg_reg ? bits_reg : 64'd0;
    assign t1 = v_reg[7] + big_sigma1(v_reg[4]) + choose(v_reg[4], v_reg[5], v_reg[6])
              + ROUND_K[round_reg] + sched_reg[0];
    assign t2 = big_sigma0(v_reg[0]) + majority(v_reg[0], v_reg[1], v_reg[2]);
    assign new_w = small_sigma1(sched_reg[14]) + sched_reg[9]
                 + small_sigma0(sched_reg[1]) + sched_reg[0];

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        latched_next = latched_reg;
        in_msg_next  = in_msg_reg;
        fill_next    = fill_reg;
        bits_next    = bits_reg;
        round_next   = round_reg;
        idx_next     = idx_reg;
        pad_next     = pad_reg;
        final_next   = final_reg;
        first_next   = first_reg;
        chain_next   = chain_reg;
        v_next       = v_reg;
        sched_next   = sched_reg;
        shift_byte   = 1'b0;
        shift_val    = 8'h00;

        case (state_reg)
            ST_IDLE:
            begin
                if (msg.valid)
                begin
                    // The first request of a message picks the initial values.
                    if (!in_msg_reg)
                    begin
                        latched_next = mode_reg;
                        if (mode_reg)
                        begin
                            chain_next = IV_256;
                        end
                        else
                        begin
                            chain_next = IV_224;
                        end
                    end
                    in_msg_next = 1'b1;
                    if (msg.kind == KIND_BYTE)
                    begin
                        shift_byte = 1'b1;
                        shift_val  = msg.data_byte;
                        bits_next  = bits_eff + 64'd8;
                        fill_next  = fill_eff + 6'd1;
                        if (fill_eff == LAST_POS)
                        begin
                            state_next = ST_COMPRESS;
                            round_next = 6'd0;
                            pad_next   = 1'b0;
                            v_next     = chain_reg;
                        end
                    end
                    else
                    begin
                        fill_next  = fill_eff;
                        bits_next  = bits_eff;
                        first_next = 1'b1;
                        final_next = (fill_eff < LENGTH_POS);
                        pad_next   = 1'b1;
                        state_next = ST_PAD;
                    end
                end
            end

            ST_PAD:
            begin
                // Marker byte, then zeros, then the bit count in the final block.
                shift_byte = 1'b1;
                if (first_reg)
                begin
                    shift_val = PAD_MARK;
                end
                else if (final_reg && (fill_reg >= LENGTH_POS))
                begin
                    shift_val = bits_reg[{~fill_reg[2:0], 3'b000} +: 8];
                end
                first_next = 1'b0;
                fill_next  = fill_reg + 6'd1;
                if (fill_reg == LAST_POS)
                begin
                    state_next = ST_COMPRESS;
                    round_next = 6'd0;
                    v_next     = chain_reg;
                end
            end

            ST_COMPRESS:
            begin
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                for (int k = 0; k < 15; k++)
                begin
                    sched_next[k] = sched_reg[k + 1];
                end
                sched_next[15] = new_w;
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end

            ST_ADD:
            begin
                for (int k = 0; k < 8; k++)
                begin
                    chain_next[k] = chain_reg[k] + v_reg[k];
                end
                if (!pad_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (final_reg)
                begin
                    state_next = ST_OUTPUT;
                    idx_next   = 3'd0;
                end
                else
                begin
                    state_next = ST_PAD;
                    final_next = 1'b1;
                end
            end

            ST_OUTPUT:
            begin
                if (dig.ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        state_next  = ST_IDLE;
                        in_msg_next = 1'b0;
                        fill_next   = 6'd0;
                        bits_next   = 64'd0;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Bytes enter the low end of the window; after 64 bytes word 0 is the first word.
        if (shift_byte)
        begin
            for (int k = 0; k < 15; k++)
            begin
                sched_next[k] = {sched_reg[k][23:0], sched_reg[k + 1][31:24]};
            end
            sched_next[15] = {sched_reg[15][23:0], shift_val};
        end
    end

    // Control and chaining registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            latched_reg <= 1'b1;
            in_msg_reg  <= 1'b0;
            fill_reg    <= 6'd0;
            bits_reg    <= 64'd0;
            round_reg   <= 6'd0;
            idx_reg     <= 3'd0;
            pad_reg     <= 1'b0;
            final_reg   <= 1'b0;
            first_reg   <= 1'b0;
            chain_reg   <= IV_256;
        end
        else
        begin
            state_reg   <= state_next;
            latched_reg <= latched_next;
            in_msg_reg  <= in_msg_next;
            fill_reg    <= fill_next;
            bits_reg    <= bits_next;
            round_reg   <= round_next;
            idx_reg     <= idx_next;
            pad_reg     <= pad_next;
            final_reg   <= final_next;
            first_reg   <= first_next;
            chain_reg   <= chain_next;
        end
    end

    // Working variables and schedule window.
    always_ff @(posedge clk)
    begin
        v_reg     <= v_next;
        sched_reg <= sched_next;
    end

    // Handshakes and result payload.
    assign msg.ready       = (state_reg == ST_IDLE);
    assign dig.valid       = (state_reg == ST_OUTPUT);
    assign dig.word_index  = idx_reg;
    assign dig.last_word   = (idx_reg == 3'd7);
    assign dig.digest_word = ((idx_reg == 3'd7) && !latched_reg) ? 32'd0 : chain_reg[idx_reg];

    // Checks.
    `SHA2H_ASSERT_NOW(a_no_overlap, msg.ready, !dig.valid, "request taken while results pending")
    `SHA2H_ASSERT_NEXT(a_round_end, (state_reg == ST_COMPRESS) && (round_reg == 6'd63),
        state_reg == ST_ADD, "compression did not end after 64 rounds")
    `SHA2H_ASSERT_NEXT(a_block_full,
        msg.valid && msg.ready && (msg.kind == KIND_BYTE) && in_msg_reg
            && (fill_reg == LAST_POS),
        (state_reg == ST_COMPRESS) && (round_reg == 6'd0), "full block not compressed")
    `SHA2H_ASSERT_NEXT(a_digest_done, dig.valid && dig.ready && dig.last_word,
        msg.ready && !in_msg_reg && (bits_reg == 64'd0), "state not cleared after digest")

endmodule

`default_nettype wire

### verif/sha2h_digest_checker.sv
// Digest checker for the SHA-256/SHA-224 hasher: mirrors the mode register, predicts
// every digest word from the accepted requests and compares the returned words in order.
// Depends on sha2h_pkg, sha2h_msg_if and sha2h_digest_if.
`default_nettype none

module sha2h_digest_checker
    import sha2h_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    sha2h_msg_if             msg,
    sha2h_digest_if          dig,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               error_count,
    output int               pending_words
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] MODE_ADDR = {REG_MODE, 2'b00};

    typedef struct {
        word_t      digest_word;
        logic [2:0] word_index;
        logic       last_word;
    } digest_entry_t;

    // Predicted hasher state.
    logic [7:0]    blk [0:BLOCK_BYTES-1];
    logic [5:0]    fill;
    logic [63:0]   bit_len;
    chain_t        chain;
    bit            msg_open;
    bit            take_256;
    bit            mode_reg;

    digest_entry_t digest_queue [$];
    digest_entry_t want;
    digest_entry_t word_out;
    int            pad_pos;

    function automatic word_t rotate_right(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One 64-round compression of the current block into the chaining words.
    function automatic void compress_block();
        word_t w [0:15];
        word_t v [0:7];
        word_t t1, t2, nw, x, y;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        end
        for (int i = 0; i < 8; i++)
        begin
            v[i] = chain[i];
        end
        for (int r = 0; r < 64; r++)
        begin
            if (r < 16)
            begin
                nw = w[r];
            end
            else
            begin
                x  = w[(r - 15) % 16];
                y  = w[(r - 2) % 16];
                nw = w[r % 16]
                   + (rotate_right(x, 7) ^ rotate_right(x, 18) ^ (x >> 3))
                   + w[(r - 7) % 16]
                   + (rotate_right(y, 17) ^ rotate_right(y, 19) ^ (y >> 10));
                w[r % 16] = nw;
            end
            t1 = v[7]
               + (rotate_right(v[4], 6) ^ rotate_right(v[4], 11) ^ rotate_right(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6]))
               + ROUND_K[r] + nw;
            t2 = (rotate_right(v[0], 2) ^ rotate_right(v[0], 13) ^ rotate_right(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
        begin
            chain[i] = chain[i] + v[i];
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      = 1'b1;
            take_256      = 1'b1;
            msg_open      = 1'b0;
            fill          = '0;
            bit_len       = '0;
            chain         = IV_256;
            digest_queue.delete();
            error_count   = 0;
            pending_words = 0;
        end
        else
        begin
            // Mirror register writes.
            if (psel && penable && pwrite && pready && paddr == MODE_ADDR)
            begin
                mode_reg = pwdata[0];
            end

            // Accepted request: the first one of a message latches the mode.
            if (msg.valid && msg.ready)
            begin
                if (!msg_open)
                begin
                    take_256 = mode_reg;
                    if (take_256)
                        chain = IV_256;
                    else
                        chain = IV_224;
                    fill     = '0;
                    bit_len  = '0;
                    msg_open = 1'b1;
                end

                if (msg.kind == KIND_BYTE)
                begin
                    blk[fill] = msg.data_byte;
                    bit_len   = bit_len + 64'd8;
                    fill      = fill + 6'd1;
                    if (fill == 6'd0)
                        compress_block();
                end
                else
                begin
                    // Pad with the marker, zeros and the bit count; spill into a
                    // second block when the count no longer fits.
                    pad_pos      = fill;
                    blk[pad_pos] = PAD_MARK;
                    pad_pos++;
                    if (pad_pos > BLOCK_BYTES - 8)
                    begin
                        for (int j = pad_pos; j < BLOCK_BYTES; j++)
                            blk[j] = 8'h00;
                        compress_block();
                        pad_pos = 0;
                    end
                    for (int j = pad_pos; j < BLOCK_BYTES - 8; j++)
                        blk[j] = 8'h00;
                    for (int j = 0; j < 8; j++)
                        blk[BLOCK_BYTES - 8 + j] = bit_len[63 - 8*j -: 8];
                    compress_block();

                    for (int i = 0; i < 8; i++)
                    begin
                        word_out.digest_word = (i == 7 && !take_256) ? 32'h0 : chain[i];
                        word_out.word_index  = 3'(i);
                        word_out.last_word   = (i == 7);
                        digest_queue.push_back(word_out);
                    end
                    fill     = '0;
                    bit_len  = '0;
                    msg_open = 1'b0;
                end
            end

            // Accepted digest word against the oldest prediction.
            if (dig.valid && dig.ready)
            begin
                if (digest_queue.size() == 0)
                begin
                    $error("unexpected digest word %h (index %0d)",
                           dig.digest_word, dig.word_index);
                    error_count++;
                end
                else
                begin
                    want = digest_queue.pop_front();
                    if (dig.digest_word !== want.digest_word)
                    begin
                        $error("digest_word mismatch: expected %h, got %h",
                               want.digest_word, dig.digest_word);
                        error_count++;
                    end
                    if (dig.word_index !== want.word_index)
                    begin
                        $error("word_index mismatch: expected %0d, got %0d",
                               want.word_index, dig.word_index);
                        error_count++;
                    end
                    if (dig.last_word !== want.last_word)
                    begin
                        $error("last_word mismatch: expected %0d, got %0d",
                               want.last_word, dig.last_word);
                        error_count++;
                    end
                end
            end

            pending_words = digest_queue.size();
        end
    end

endmodule

`default_nettype wire

### verif/tb_sha256_sha224_hasher.sv
// Top of the SHA-256/SHA-224 hasher testbench: clock, reset, request stimulus with
// random idling, mode register writes and the verdict. Depends on sha2h_pkg, both
// channel interfaces, the hasher and sha2h_digest_checker.
`default_nettype none

module tb_sha256_sha224_hasher;
    import sha2h_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TARGET_ITEMS = 470;
    localparam int CALM_ITEMS   = 400;
    localparam int SETTLE       = 256;
    localparam int STALL_LIMIT  = 4000;
    localparam logic [2:0] MODE_ADDR = {REG_MODE, 2'b00};

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          error_count;
    int          pending_words;

    sha2h_msg_if    msg_ch ();
    sha2h_digest_if dig_ch ();

    sha256_sha224_hasher dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .msg     (msg_ch),
        .dig     (dig_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    sha2h_digest_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .msg           (msg_ch),
        .dig           (dig_ch),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .error_count   (error_count),
        .pending_words (pending_words)
    );

    always #5 clk = ~clk;

    // Run statistics and the switch that turns idling off near the end.
    bit          calm_tail;
    int          items_sent;
    int          messages_256;
    int          messages_224;
    int          longest_msg;
    bit          cur_mode;
    logic [7:0]  body [$];
    int          stall_cycles;

    // Digest receiver: ready drops in random bursts until the calm tail.
    initial
    begin
        int hold;
        hold         = 0;
        dig_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (calm_tail || !rst_n)
            begin
                dig_ch.ready <= rst_n;
                hold = 0;
            end
            else if (hold > 0)
            begin
                dig_ch.ready <= 1'b0;
                hold--;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                dig_ch.ready <= 1'b0;
                hold = $urandom_range(0, 3);
            end
            else
            begin
                dig_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no accepted request, digest word or register write.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((msg_ch.valid && msg_ch.ready) || (dig_ch.valid && dig_ch.ready)
                || (psel && penable))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
        else
        begin
            stall_cycles <= 0;
        end
    end

    // Present one request, with an optional idle burst before it, and wait for acceptance.
    task automatic send_request(input logic k, input logic [7:0] b);
        int gap;
        if (!calm_tail && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 4);
            msg_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        msg_ch.valid     <= 1'b1;
        msg_ch.kind      <= k;
        msg_ch.data_byte <= b;
        do
            @(posedge clk);
        while (!msg_ch.ready);
        @(negedge clk);
        items_sent++;
        if (items_sent >= CALM_ITEMS)
            calm_tail = 1'b1;
    endtask

    // Send the bytes in body followed by a finish request with a random ignored byte.
    task automatic send_message();
        foreach (body[i])
            send_request(KIND_BYTE, body[i]);
        send_request(KIND_FINISH, 8'($urandom_range(0, 255)));
        if (cur_mode)
            messages_256++;
        else
            messages_224++;
        if (body.size() > longest_msg)
            longest_msg = body.size();
    endtask

    // Let every digest drain and the block settle, then write the mode register.
    task automatic write_mode(input bit value);
        msg_ch.valid <= 1'b0;
        wait (pending_words == 0);
        repeat (SETTLE) @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MODE_ADDR;
        pwdata  <= {31'($urandom_range(0, 32'h7fff_ffff)), value};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        cur_mode  = value;
    endtask

    // Random message length: often short, some at the padding boundaries, some long.
    // The length is trimmed so that the run ends close to the target request count.
    task automatic fill_random_body();
        int len;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            len = $urandom_range(0, 8);
        else if (sel < 6)
        begin
            case ($urandom_range(0, 5))
                0: len = 55;
                1: len = 56;
                2: len = 63;
                3: len = 64;
                4: len = 119;
                default: len = 120;
            endcase
        end
        else
            len = $urandom_range(0, 100);
        if (len > TARGET_ITEMS - items_sent - 1)
            len = TARGET_ITEMS - items_sent - 1;
        body.delete();
        repeat (len) body.push_back(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int phase;
        int msgs;
        msg_ch.valid     = 1'b0;
        msg_ch.kind      = KIND_BYTE;
        msg_ch.data_byte = 8'h00;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        rst_n            = 1'b0;
        calm_tail        = 1'b0;
        items_sent       = 0;
        messages_256     = 0;
        messages_224     = 0;
        longest_msg      = 0;
        cur_mode         = 1'b1;
        phase            = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty message, "abc" and the byte extremes in the reset mode.
        body.delete();
        send_message();
        body = '{8'h61, 8'h62, 8'h63};
        send_message();
        body = '{8'h00, 8'hff};
        send_message();

        // Directed: empty message, "abc" and one 0xff byte in SHA-224 mode, then back to SHA-256.
        write_mode(1'b0);
        body.delete();
        send_message();
        body = '{8'h61, 8'h62, 8'h63};
        send_message();
        body = '{8'hff};
        send_message();
        write_mode(1'b1);

        // Random phases, each under its own mode, separated by a full drain.
        while (items_sent < TARGET_ITEMS)
        begin
            if (phase > 0)
                write_mode((phase < 3) ? phase[0] : bit'($urandom_range(0, 1)));
            msgs = $urandom_range(2, 6);
            repeat (msgs)
            begin
                if (items_sent < TARGET_ITEMS)
                begin
                    fill_random_body();
                    send_message();
                end
            end
            phase++;
        end

        msg_ch.valid <= 1'b0;
        wait (pending_words == 0);
        repeat (SETTLE) @(negedge clk);

        $display("Hashed %0d SHA-256 and %0d SHA-224 messages from %0d requests,",
                 messages_256, messages_224, items_sent);
        $display("lengths up to %0d bytes across %0d mode phases.", longest_msg, phase);
        if (error_count == 0 && pending_words == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
